[sv/ccbr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccbr_pkg: shared types and constants of the claim/commit byte ring
// Action and status codes, position widths, controller states and commands.
// ----------------------------------------------------------------------------
package ccbr_pkg;

	// Position and count width: positions wrap modulo 512
	localparam int POS_W = 9;
	localparam int DATA_W = 8;
	localparam int STAT_W = 2;

	// Default store depth
	localparam int STORE_DEPTH_DEF = 256;

	// Capacity after reset
	localparam logic [POS_W-1:0] CAP_RESET = 9'd256;

	typedef enum logic [1:0] {
		ACT_PUT_BYTE   = 2'd0,
		ACT_PUT_FINISH = 2'd1,
		ACT_GET_BYTE   = 2'd2,
		ACT_GET_FINISH = 2'd3
	} action_t;

	localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
	localparam logic [STAT_W-1:0] STAT_REFUSED    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_OVERCOMMIT = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RESP
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic resp;
	} cmd_t;

endpackage

[sv/ccbr_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccbr_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ccbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/ccbr_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccbr_ctrl: controller of the claim/commit byte ring
// Sequences each item through load, execute and respond.
// ----------------------------------------------------------------------------
module ccbr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output logic            done,
	output ccbr_pkg::cmd_t  cmd
);

	ccbr_pkg::state_t state_q, state_d;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ccbr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance through the item sequence
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ccbr_pkg::ST_IDLE: begin
				if (start) state_d = ccbr_pkg::ST_EXEC;
			end
			ccbr_pkg::ST_EXEC: state_d = ccbr_pkg::ST_RESP;
			ccbr_pkg::ST_RESP: state_d = ccbr_pkg::ST_IDLE;
			default: state_d = ccbr_pkg::ST_IDLE;
		endcase
	end

	// Drive commands and handshake
	always_comb begin
		cmd.load = (state_q == ccbr_pkg::ST_IDLE) && start;
		cmd.exec = (state_q == ccbr_pkg::ST_EXEC);
		cmd.resp = (state_q == ccbr_pkg::ST_RESP);
		busy     = (state_q != ccbr_pkg::ST_IDLE);
		done     = cmd.resp;
	end

	// An accepted item moves to execute
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> cmd.exec)
		else $error("accepted item did not enter execute");

	// A result follows the execute state directly
	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> done)
		else $error("no result after execute");

	// A result strobe lasts one cycle and frees the block
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!done && !busy))
		else $error("result strobe longer than one cycle");

	// Busy stays high from accept until the result
	a_busy_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> (busy && !done))
		else $error("busy dropped during execute");

endmodule

[sv/ccbr_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccbr_dpath: datapath of the claim/commit byte ring
// Input registers, reserve/commit/wrap positions, byte store and results.
// ----------------------------------------------------------------------------
module ccbr_dpath #(
	parameter int STORE_DEPTH = ccbr_pkg::STORE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ccbr_pkg::cmd_t                  cmd,
	input  logic [1:0]                      action,
	input  logic [ccbr_pkg::DATA_W-1:0]     write_data,
	input  logic [ccbr_pkg::POS_W-1:0]      commit_count,
	input  logic                            cfg_valid,
	input  logic [ccbr_pkg::POS_W-1:0]      cfg_data,
	output logic [ccbr_pkg::STAT_W-1:0]     status,
	output logic [ccbr_pkg::DATA_W-1:0]     read_data,
	output logic [ccbr_pkg::POS_W-1:0]      open_slots,
	output logic [ccbr_pkg::POS_W-1:0]      available_bytes
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int LIM = (STORE_DEPTH < 256) ? STORE_DEPTH : 256;
	localparam logic [ccbr_pkg::POS_W-1:0] LIM_P = ccbr_pkg::POS_W'(LIM);

	// Item registers
	ccbr_pkg::action_t                action_q;
	logic [ccbr_pkg::DATA_W-1:0]      wdata_q;
	logic [ccbr_pkg::POS_W-1:0]       count_q;

	// Positions and configuration
	logic [ccbr_pkg::POS_W-1:0] wr_res_q, wr_com_q, wr_base_q;
	logic [ccbr_pkg::POS_W-1:0] rd_res_q, rd_com_q, rd_base_q;
	logic [ccbr_pkg::POS_W-1:0] cap_raw_q;
	logic [ccbr_pkg::STAT_W-1:0] status_q;
	logic                        rd_hit_q;

	logic [ccbr_pkg::POS_W-1:0] cap;
	logic [ccbr_pkg::POS_W-1:0] wr_off, rd_off, used, avail_raw;
	logic                       wr_room, rd_room, free_ok, avail_ok;
	logic [ccbr_pkg::POS_W-1:0] fin_head, fin_tail, fin_base, claimed, new_tail;
	logic                       over, base_adv;
	logic                       ram_we, ram_re;
	logic [ccbr_pkg::DATA_W-1:0] ram_rdata;

	// Clamp capacity to one..limit
	always_comb begin
		cap = cap_raw_q;
		if (cap == '0) cap = ccbr_pkg::POS_W'(1);
		if (cap > LIM_P) cap = LIM_P;
	end

	// Slot offsets and fill levels
	always_comb begin
		wr_off = wr_res_q - wr_base_q;
		if (wr_off >= cap) wr_off = wr_off - cap;
		wr_room = wr_off < cap;
		rd_off = rd_res_q - rd_base_q;
		if (rd_off >= cap) rd_off = rd_off - cap;
		rd_room = rd_off < cap;
		used = wr_res_q - rd_com_q;
		free_ok = used < cap;
		avail_raw = wr_com_q - rd_res_q;
		avail_ok = avail_raw != '0;
	end

	// Select the side a finish action works on
	always_comb begin
		if (action_q == ccbr_pkg::ACT_PUT_FINISH) begin
			fin_head = wr_res_q;
			fin_tail = wr_com_q;
			fin_base = wr_base_q;
		end else begin
			fin_head = rd_res_q;
			fin_tail = rd_com_q;
			fin_base = rd_base_q;
		end
		claimed  = fin_head - fin_tail;
		over     = count_q > claimed;
		new_tail = fin_tail + count_q;
		base_adv = (new_tail - fin_base) >= cap;
	end

	assign ram_we = cmd.exec && (action_q == ccbr_pkg::ACT_PUT_BYTE) && free_ok && wr_room;
	assign ram_re = cmd.exec && (action_q == ccbr_pkg::ACT_GET_BYTE) && avail_ok && rd_room;

	// Capture the item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= ccbr_pkg::action_t'(action);
			wdata_q  <= write_data;
			count_q  <= commit_count;
		end
	end

	// Write capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_raw_q <= ccbr_pkg::CAP_RESET;
		end else if (cfg_valid) begin
			cap_raw_q <= cfg_data;
		end
	end

	// Execute the action: update positions and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_res_q  <= '0;
			wr_com_q  <= '0;
			wr_base_q <= '0;
			rd_res_q  <= '0;
			rd_com_q  <= '0;
			rd_base_q <= '0;
			status_q  <= ccbr_pkg::STAT_OK;
			rd_hit_q  <= 1'b0;
		end else if (cmd.exec) begin
			status_q <= ccbr_pkg::STAT_OK;
			rd_hit_q <= ram_re;
			unique case (action_q)
				ccbr_pkg::ACT_PUT_BYTE: begin
					if (ram_we) wr_res_q <= wr_res_q + 1'b1;
					else status_q <= ccbr_pkg::STAT_REFUSED;
				end
				ccbr_pkg::ACT_GET_BYTE: begin
					if (ram_re) rd_res_q <= rd_res_q + 1'b1;
					else status_q <= ccbr_pkg::STAT_REFUSED;
				end
				ccbr_pkg::ACT_PUT_FINISH: begin
					if (over) begin
						status_q <= ccbr_pkg::STAT_OVERCOMMIT;
					end else begin
						wr_com_q <= new_tail;
						wr_res_q <= new_tail;
						if (base_adv) wr_base_q <= wr_base_q + cap;
					end
				end
				ccbr_pkg::ACT_GET_FINISH: begin
					if (over) begin
						status_q <= ccbr_pkg::STAT_OVERCOMMIT;
					end else begin
						rd_com_q <= new_tail;
						rd_res_q <= new_tail;
						if (base_adv) rd_base_q <= rd_base_q + cap;
					end
				end
				default: status_q <= ccbr_pkg::STAT_OK;
			endcase
		end
	end

	// Byte store
	ccbr_ram #(
		.WIDTH (ccbr_pkg::DATA_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (AW'(wr_off)),
		.wdata (wdata_q),
		.re    (ram_re),
		.raddr (AW'(rd_off)),
		.rdata (ram_rdata)
	);

	// Form the result from the updated positions
	always_comb begin
		status          = status_q;
		read_data       = rd_hit_q ? ram_rdata : '0;
		open_slots      = free_ok ? (cap - used) : '0;
		available_bytes = (avail_raw > cap) ? cap : avail_raw;
	end

	// A store write only happens on a granted put byte
	a_we_put: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (wr_res_q == $past(wr_res_q) + 1'b1))
		else $error("store write without reserve advance");

	// A granted read reports status ok
	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |=> (rd_hit_q && status_q == ccbr_pkg::STAT_OK))
		else $error("granted read with bad status");

	// Write and read are never issued together
	a_we_re: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("store write and read in one cycle");

endmodule

[sv/claim_commit_byte_ring_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// claim_commit_byte_ring_top: byte ring with claim and commit on both sides
// Sequence: start is accepted in idle; the item then passes the execute and
// respond states, and done pulses in respond. A new item is taken only once
// the block is idle again (load, execute, respond); the receiver cannot stall.
// Reset: positions cleared, capacity 256; store contents stay undefined.
// ----------------------------------------------------------------------------
module claim_commit_byte_ring_top #(
	parameter int STORE_DEPTH = ccbr_pkg::STORE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    action,
	input  logic [ccbr_pkg::DATA_W-1:0]   write_data,
	input  logic [ccbr_pkg::POS_W-1:0]    commit_count,
	output logic                          done,
	output logic [ccbr_pkg::STAT_W-1:0]   status,
	output logic [ccbr_pkg::DATA_W-1:0]   read_data,
	output logic [ccbr_pkg::POS_W-1:0]    open_slots,
	output logic [ccbr_pkg::POS_W-1:0]    available_bytes,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ccbr_pkg::POS_W-1:0]    cfg_data
);

	ccbr_pkg::cmd_t cmd;

	// Configuration is always taken
	assign cfg_ready = 1'b1;

	ccbr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	ccbr_dpath #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.action          (action),
		.write_data      (write_data),
		.commit_count    (commit_count),
		.cfg_valid       (cfg_valid && cfg_ready),
		.cfg_data        (cfg_data),
		.status          (status),
		.read_data       (read_data),
		.open_slots      (open_slots),
		.available_bytes (available_bytes)
	);

endmodule

[test/tb_claim_commit_byte_ring_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_claim_commit_byte_ring_top: self-checking bench for the claim/commit ring
// A short table of hand-picked accesses opens the run: empty and full refusal,
// over-commit on both sides, peek by a zero commit, and a zero capacity.
// Random phases under several capacity settings follow. They alternate fill
// and drain runs and add commit noise. A shadow copy of the ring predicts
// each reply not set in the table; the monitor checks each done pulse field by field.
// ----------------------------------------------------------------------------
module tb_claim_commit_byte_ring_top;

	localparam int DEPTH       = ccbr_pkg::STORE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 215;

	typedef struct packed {
		logic [ccbr_pkg::STAT_W-1:0] status;
		logic [ccbr_pkg::DATA_W-1:0] rdata;
		logic [ccbr_pkg::POS_W-1:0]  free;
		logic [ccbr_pkg::POS_W-1:0]  avail;
	} reply_t;

	typedef struct {
		bit                          is_cfg;
		logic [ccbr_pkg::POS_W-1:0]  cfg_val;
		ccbr_pkg::action_t           act;
		logic [ccbr_pkg::DATA_W-1:0] wdata;
		logic [ccbr_pkg::POS_W-1:0]  count;
		bit                          typed;
		reply_t                      want;
	} step_row_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [1:0]                    action;
	logic [ccbr_pkg::DATA_W-1:0]   write_data;
	logic [ccbr_pkg::POS_W-1:0]    commit_count;
	logic                          done;
	logic [ccbr_pkg::STAT_W-1:0]   status;
	logic [ccbr_pkg::DATA_W-1:0]   read_data;
	logic [ccbr_pkg::POS_W-1:0]    open_slots;
	logic [ccbr_pkg::POS_W-1:0]    available_bytes;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [ccbr_pkg::POS_W-1:0]    cfg_data;

	// Shadow ring: byte store, positions and capacity as the block should hold them
	logic [ccbr_pkg::DATA_W-1:0] shadow_bytes [DEPTH];
	bit                          shadow_written [DEPTH];
	logic [ccbr_pkg::POS_W-1:0]  wr_claim, wr_commit, wr_wrap;
	logic [ccbr_pkg::POS_W-1:0]  rd_claim, rd_commit, rd_wrap;
	logic [ccbr_pkg::POS_W-1:0]  cap_reg;

	reply_t    ring_reply_q [$];
	step_row_t directed_q [$];
	int        mismatch_count = 0;
	int        cycle_count = 0;

	claim_commit_byte_ring_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.action          (action),
		.write_data      (write_data),
		.commit_count    (commit_count),
		.done            (done),
		.status          (status),
		.read_data       (read_data),
		.open_slots      (open_slots),
		.available_bytes (available_bytes),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Capacity in effect: zero acts as one, large values clamp to the store
	function automatic int ring_span();
		int c;
		c = int'(cap_reg);
		if (c == 0) c = 1;
		if (c > 256) c = 256;
		if (c > DEPTH) c = DEPTH;
		return c;
	endfunction

	// Distance a - b on the 9-bit position circle
	function automatic int lap(logic [ccbr_pkg::POS_W-1:0] a, logic [ccbr_pkg::POS_W-1:0] b);
		logic [ccbr_pkg::POS_W-1:0] d;
		d = a - b;
		return int'(d);
	endfunction

	function automatic int free_slots(int span);
		int used;
		used = lap(wr_claim, rd_commit);
		return (used >= span) ? 0 : span - used;
	endfunction

	function automatic int avail_slots(int span);
		int v;
		v = lap(wr_commit, rd_claim);
		return (v > span) ? span : v;
	endfunction

	// Store index of the next slot of one side; room is what is left before the wrap
	function automatic int slot_at(logic [ccbr_pkg::POS_W-1:0] head,
			logic [ccbr_pkg::POS_W-1:0] base, int span, output int room);
		int off;
		off = lap(head, base);
		if (off >= span) off -= span;
		room = (off < span) ? span - off : 0;
		if (off >= DEPTH) off = off % DEPTH;
		return off;
	endfunction

	// Commit count claimed bytes on one side, drop the rest of the claim
	function automatic logic [ccbr_pkg::STAT_W-1:0] close_claim(bit reader_side, int count,
			int span);
		logic [ccbr_pkg::POS_W-1:0] head, tail, base;
		head = reader_side ? rd_claim : wr_claim;
		tail = reader_side ? rd_commit : wr_commit;
		base = reader_side ? rd_wrap : wr_wrap;
		if (count > lap(head, tail)) return ccbr_pkg::STAT_OVERCOMMIT;
		tail = tail + ccbr_pkg::POS_W'(count);
		head = tail;
		if (lap(tail, base) >= span) base = base + ccbr_pkg::POS_W'(span);
		if (reader_side) begin
			rd_claim = head;
			rd_commit = tail;
			rd_wrap = base;
		end else begin
			wr_claim = head;
			wr_commit = tail;
			wr_wrap = base;
		end
		return ccbr_pkg::STAT_OK;
	endfunction

	// Apply one access to the shadow ring and return the reply it must produce
	function automatic reply_t ring_predict(ccbr_pkg::action_t act,
			logic [ccbr_pkg::DATA_W-1:0] wd, logic [ccbr_pkg::POS_W-1:0] cnt);
		reply_t r;
		int span, room, idx;
		span = ring_span();
		r = '0;
		r.status = ccbr_pkg::STAT_OK;
		case (act)
			ccbr_pkg::ACT_PUT_BYTE: begin
				idx = slot_at(wr_claim, wr_wrap, span, room);
				if (free_slots(span) == 0 || room == 0) begin
					r.status = ccbr_pkg::STAT_REFUSED;
				end else begin
					shadow_bytes[idx] = wd;
					shadow_written[idx] = 1'b1;
					wr_claim = wr_claim + 1'b1;
				end
			end
			ccbr_pkg::ACT_PUT_FINISH: r.status = close_claim(1'b0, int'(cnt), span);
			ccbr_pkg::ACT_GET_BYTE: begin
				idx = slot_at(rd_claim, rd_wrap, span, room);
				if (avail_slots(span) == 0 || room == 0) begin
					r.status = ccbr_pkg::STAT_REFUSED;
				end else begin
					r.rdata = shadow_bytes[idx];
					rd_claim = rd_claim + 1'b1;
				end
			end
			default: r.status = close_claim(1'b1, int'(cnt), span);
		endcase
		r.free = ccbr_pkg::POS_W'(free_slots(span));
		r.avail = ccbr_pkg::POS_W'(avail_slots(span));
		return r;
	endfunction

	// True when a get byte would succeed on a store entry never written
	function automatic bit blank_read_ahead();
		int span, room, idx;
		span = ring_span();
		idx = slot_at(rd_claim, rd_wrap, span, room);
		return avail_slots(span) != 0 && room != 0 && !shadow_written[idx];
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		mismatch_count++;
		$display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
	endtask

	task automatic add_row(bit is_cfg, logic [ccbr_pkg::POS_W-1:0] cfg_val,
			ccbr_pkg::action_t act, logic [ccbr_pkg::DATA_W-1:0] wd,
			logic [ccbr_pkg::POS_W-1:0] cnt, bit typed,
			logic [ccbr_pkg::STAT_W-1:0] st, logic [ccbr_pkg::DATA_W-1:0] rd,
			logic [ccbr_pkg::POS_W-1:0] fr, logic [ccbr_pkg::POS_W-1:0] av);
		step_row_t row;
		row.is_cfg = is_cfg;
		row.cfg_val = cfg_val;
		row.act = act;
		row.wdata = wd;
		row.count = cnt;
		row.typed = typed;
		row.want = '{status: st, rdata: rd, free: fr, avail: av};
		directed_q.push_back(row);
	endtask

	// Present one item, hold it until accepted, then log its reply
	task automatic issue_item(ccbr_pkg::action_t act, logic [ccbr_pkg::DATA_W-1:0] wd,
			logic [ccbr_pkg::POS_W-1:0] cnt, bit typed, reply_t want);
		reply_t pred;
		start <= 1'b1;
		action <= act;
		write_data <= wd;
		commit_count <= cnt;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		pred = ring_predict(act, wd, cnt);
		ring_reply_q.push_back(typed ? want : pred);
	endtask

	// Drop start now and then, with junk on the fields
	task automatic maybe_idle(bit allow);
		if (allow && $urandom_range(0, 99) < 33) begin
			start <= 1'b0;
			action <= 2'($urandom_range(0, 3));
			write_data <= 8'($urandom_range(0, 255));
			commit_count <= 9'($urandom_range(0, 256));
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Drain all pending replies, let the block settle, then write the capacity
	task automatic write_capacity(logic [ccbr_pkg::POS_W-1:0] cap_value);
		start <= 1'b0;
		while (ring_reply_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= cap_value;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		cfg_valid <= 1'b0;
		cap_reg = cap_value;
	endtask

	// Check each done pulse against the oldest pending reply
	always @(posedge clk) begin
		reply_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (ring_reply_q.size() == 0) begin
				report_mismatch("done with nothing pending", 1, 0);
			end else begin
				want = ring_reply_q.pop_front();
				if (status !== want.status)
					report_mismatch("status", int'(status), int'(want.status));
				if (read_data !== want.rdata)
					report_mismatch("read_data", int'(read_data), int'(want.rdata));
				if (open_slots !== want.free)
					report_mismatch("open_slots", int'(open_slots), int'(want.free));
				if (available_bytes !== want.avail)
					report_mismatch("available_bytes", int'(available_bytes),
						int'(want.avail));
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		step_row_t                   row;
		ccbr_pkg::action_t           act;
		logic [ccbr_pkg::DATA_W-1:0] wd;
		logic [ccbr_pkg::POS_W-1:0]  cnt;
		logic [ccbr_pkg::POS_W-1:0]  phase_caps [8];
		int                          claimed, roll, run_len;
		bit                          fill_mode;

		arst_n <= 1'b0;
		start <= 1'b0;
		action <= ccbr_pkg::ACT_PUT_BYTE;
		write_data <= '0;
		commit_count <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;

		wr_claim = '0;
		wr_commit = '0;
		wr_wrap = '0;
		rd_claim = '0;
		rd_commit = '0;
		rd_wrap = '0;
		cap_reg = ccbr_pkg::CAP_RESET;
		foreach (shadow_written[i]) shadow_written[i] = 1'b0;

		// Empty refusal and over-commit straight after reset
		add_row(0, 0, ccbr_pkg::ACT_GET_BYTE, 8'h00, 9'd0,
			1, ccbr_pkg::STAT_REFUSED, 8'h00, 9'd256, 9'd0);
		add_row(0, 0, ccbr_pkg::ACT_GET_FINISH, 8'h00, 9'd1,
			1, ccbr_pkg::STAT_OVERCOMMIT, 8'h00, 9'd256, 9'd0);
		add_row(0, 0, ccbr_pkg::ACT_PUT_FINISH, 8'h00, 9'd256,
			1, ccbr_pkg::STAT_OVERCOMMIT, 8'h00, 9'd256, 9'd0);
		// Claim three, commit two, drop one
		add_row(0, 0, ccbr_pkg::ACT_PUT_BYTE, 8'hFF, 9'd0,
			1, ccbr_pkg::STAT_OK, 8'h00, 9'd255, 9'd0);
		add_row(0, 0, ccbr_pkg::ACT_PUT_BYTE, 8'h00, 9'd0,
			1, ccbr_pkg::STAT_OK, 8'h00, 9'd254, 9'd0);
		add_row(0, 0, ccbr_pkg::ACT_PUT_BYTE, 8'h5A, 9'd0,
			1, ccbr_pkg::STAT_OK, 8'h00, 9'd253, 9'd0);
		add_row(0, 0, ccbr_pkg::ACT_PUT_FINISH, 8'h00, 9'd2,
			1, ccbr_pkg::STAT_OK, 8'h00, 9'd254, 9'd2);
		// Read both, run dry, then peek by committing zero
		add_row(0, 0, ccbr_pkg::ACT_GET_BYTE, 8'h00, 9'd0,
			1, ccbr_pkg::STAT_OK, 8'hFF, 9'd254, 9'd1);
		add_row(0, 0, ccbr_pkg::ACT_GET_BYTE, 8'h00, 9'd0,
			1, ccbr_pkg::STAT_OK, 8'h00, 9'd254, 9'd0);
		add_row(0, 0, ccbr_pkg::ACT_GET_BYTE, 8'h00, 9'd0,
			1, ccbr_pkg::STAT_REFUSED, 8'h00, 9'd254, 9'd0);
		add_row(0, 0, ccbr_pkg::ACT_GET_FINISH, 8'h00, 9'd0,
			1, ccbr_pkg::STAT_OK, 8'h00, 9'd254, 9'd2);
		add_row(0, 0, ccbr_pkg::ACT_GET_BYTE, 8'h00, 9'd0, 0, '0, '0, '0, '0);
		add_row(0, 0, ccbr_pkg::ACT_GET_FINISH, 8'h00, 9'd2,
			1, ccbr_pkg::STAT_OVERCOMMIT, 8'h00, 9'd254, 9'd1);
		add_row(0, 0, ccbr_pkg::ACT_GET_FINISH, 8'h00, 9'd1, 0, '0, '0, '0, '0);
		add_row(0, 0, ccbr_pkg::ACT_PUT_FINISH, 8'h00, 9'd0, 0, '0, '0, '0, '0);
		// Zero capacity in mid-stream: acts as one slot, positions out of step
		add_row(1, 9'd0, ccbr_pkg::ACT_PUT_BYTE, '0, '0, 0, '0, '0, '0, '0);
		add_row(0, 0, ccbr_pkg::ACT_PUT_BYTE, 8'h3C, 9'd0, 0, '0, '0, '0, '0);
		add_row(0, 0, ccbr_pkg::ACT_GET_BYTE, 8'h00, 9'd0, 0, '0, '0, '0, '0);
		add_row(0, 0, ccbr_pkg::ACT_GET_FINISH, 8'h00, 9'd1, 0, '0, '0, '0, '0);
		add_row(0, 0, ccbr_pkg::ACT_PUT_FINISH, 8'h00, 9'd0, 0, '0, '0, '0, '0);
		add_row(0, 0, ccbr_pkg::ACT_PUT_BYTE, 8'h80, 9'd0, 0, '0, '0, '0, '0);
		add_row(0, 0, ccbr_pkg::ACT_PUT_BYTE, 8'h01, 9'd0, 0, '0, '0, '0, '0);
		add_row(0, 0, ccbr_pkg::ACT_PUT_FINISH, 8'h00, 9'd1, 0, '0, '0, '0, '0);
		add_row(0, 0, ccbr_pkg::ACT_GET_BYTE, 8'h00, 9'd0, 0, '0, '0, '0, '0);
		add_row(0, 0, ccbr_pkg::ACT_GET_FINISH, 8'h00, 9'd1, 0, '0, '0, '0, '0);
		add_row(1, 9'd256, ccbr_pkg::ACT_PUT_BYTE, '0, '0, 0, '0, '0, '0, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed table
		foreach (directed_q[i]) begin
			row = directed_q[i];
			if (row.is_cfg) begin
				write_capacity(row.cfg_val);
			end else begin
				issue_item(row.act, row.wdata, row.count, row.typed, row.want);
				maybe_idle(1'b1);
			end
		end

		// Random phases, one capacity each; the fourth runs without gaps
		phase_caps = '{9'd511, 9'd1, 9'd5, 9'd255, 9'd0, 9'd20, 9'd256, 9'd64};
		phase_caps[5] = 9'($urandom_range(2, 40));
		foreach (phase_caps[p]) begin
			write_capacity(phase_caps[p]);
			fill_mode = 1'b1;
			run_len = $urandom_range(20, 80);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Alternate fill and drain runs
				if (run_len == 0) begin
					fill_mode = !fill_mode;
					run_len = $urandom_range(20, 80);
				end
				run_len--;
				roll = $urandom_range(0, 99);
				if (roll < 10)
					act = ccbr_pkg::ACT_PUT_FINISH;
				else if (roll < 20)
					act = ccbr_pkg::ACT_GET_FINISH;
				else if (roll < 80)
					act = fill_mode ? ccbr_pkg::ACT_PUT_BYTE : ccbr_pkg::ACT_GET_BYTE;
				else
					act = fill_mode ? ccbr_pkg::ACT_GET_BYTE : ccbr_pkg::ACT_PUT_BYTE;
				wd = 8'($urandom_range(0, 255));

				// Mostly full or partial commits, some over-commits and noise
				claimed = (act == ccbr_pkg::ACT_PUT_FINISH) ? lap(wr_claim, wr_commit)
					: lap(rd_claim, rd_commit);
				roll = $urandom_range(0, 99);
				if (roll < 45)
					cnt = 9'(claimed);
				else if (roll < 75)
					cnt = 9'($urandom_range(0, claimed));
				else if (roll < 88)
					cnt = 9'((claimed + 3 > 256) ? 256 : claimed + $urandom_range(1, 3));
				else
					cnt = 9'($urandom_range(0, 256));

				// Never read a store entry that was never written
				if (act == ccbr_pkg::ACT_GET_BYTE && blank_read_ahead())
					act = ccbr_pkg::ACT_PUT_BYTE;

				issue_item(act, wd, cnt, 1'b0, '0);
				maybe_idle(p != 3);
			end
		end

		start <= 1'b0;
		while (ring_reply_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && ring_reply_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[filelist.f]
sv/ccbr_pkg.sv
sv/ccbr_ram.sv
sv/ccbr_ctrl.sv
sv/ccbr_dpath.sv
sv/claim_commit_byte_ring_top.sv
test/tb_claim_commit_byte_ring_top.sv
